// ===== hw/rtl/tdr_pkg.sv =====
`default_nettype none

package tdr_pkg;

   // counter width default
   localparam int TIMER_BITS_DEF = 16;

   localparam int TAG_W   = 8;
   localparam int CFG_W   = 16;
   localparam int SOUND_W = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [TAG_W-1:0] NOT_PRESSED = 8'h00;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_UPDATE_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_PERIOD   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE        = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOUND_ENABLES   = 2'd3;

   // reset values of the registers
   localparam logic [CFG_W-1:0]   UPDATE_INTERVAL_RST = 16'd50;
   localparam logic [CFG_W-1:0]   REPEAT_PERIOD_RST   = 16'd100;
   localparam logic [CFG_W-1:0]   DEBOUNCE_RST        = 16'd100;
   localparam logic [SOUND_W-1:0] SOUND_ENABLES_RST   = 3'd7;

   // sound enable bits
   localparam int SND_EN_PRESS   = 0;
   localparam int SND_EN_RELEASE = 1;
   localparam int SND_EN_REPEAT  = 2;

   // event codes
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_START = 2'd1;
   localparam logic [1:0] EV_HELD  = 2'd2;
   localparam logic [1:0] EV_END   = 2'd3;

   // sound codes
   localparam logic [1:0] SND_NONE    = 2'd0;
   localparam logic [1:0] SND_PRESS   = 2'd1;
   localparam logic [1:0] SND_REPEAT  = 2'd2;
   localparam logic [1:0] SND_RELEASE = 2'd3;

   typedef struct packed {
      logic [TAG_W-1:0] touch_tag;
      logic             panel_busy;
      logic             start_accepted;
      logic             held_accepted;
      logic             screen_changed;
   } item_type;

   typedef struct packed {
      logic [1:0]       event_kind;
      logic [TAG_W-1:0] event_tag;
      logic [1:0]       sound_kind;
      logic             refresh;
      logic [TAG_W-1:0] held_tag;
      logic             sampled;
   } result_type;

   typedef struct packed {
      logic [CFG_W-1:0]   update_interval;
      logic [CFG_W-1:0]   repeat_period;
      logic [CFG_W-1:0]   debounce;
      logic [SOUND_W-1:0] sound_enables;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tdr_state.sv =====
`default_nettype none

module tdr_state
   import tdr_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step_en,
   input  wire item_type   item,
   input  wire cfg_type    cfg,
   output      result_type result
);

   localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

   logic [TAG_W-1:0]      tag_ff, tag_in;
   logic                  deb_ff, deb_in;
   logic                  ign_ff, ign_in;
   logic [TIMER_BITS-1:0] ctr_ff, ctr_in;
   logic [TIMER_BITS-1:0] ctr_inc;
   logic [CMP_W-1:0]      ctr_cmp;

   always_comb begin
      ctr_inc = (ctr_ff != '1) ? ctr_ff + 1'b1 : ctr_ff;
      ctr_cmp = CMP_W'(ctr_inc);
      tag_in  = tag_ff;
      deb_in  = deb_ff;
      ign_in  = ign_ff;
      ctr_in  = ctr_inc;
      result  = '0;
      if (ctr_cmp >= CMP_W'(cfg.update_interval) && !item.panel_busy) begin
         result.sampled = 1'b1;
         if (tag_ff == NOT_PRESSED) begin
            if (item.touch_tag != NOT_PRESSED) begin
               tag_in            = item.touch_tag;
               result.refresh    = 1'b1;
               result.event_kind = EV_START;
               result.event_tag  = item.touch_tag;
               if (item.start_accepted) begin
                  ctr_in = '0;
                  if (cfg.sound_enables[SND_EN_PRESS]) begin
                     result.sound_kind = SND_PRESS;
                  end
               end
               ign_in = item.screen_changed;
            end else begin
               ctr_in = '0;
            end
         end else if (!deb_ff) begin
            if (item.touch_tag == tag_ff) begin
               if (ctr_cmp >= CMP_W'(cfg.repeat_period)) begin
                  result.event_kind = EV_HELD;
                  result.event_tag  = item.touch_tag;
                  if (item.held_accepted) begin
                     result.refresh = 1'b1;
                     if (cfg.sound_enables[SND_EN_REPEAT]) begin
                        result.sound_kind = SND_REPEAT;
                     end
                  end
                  ctr_in = '0;
               end
            end else if (item.touch_tag == NOT_PRESSED) begin
               ctr_in = '0;
               deb_in = 1'b1;
            end
         end else begin
            if (item.touch_tag == tag_ff) begin
               deb_in = 1'b0;
            end else if (ctr_cmp >= CMP_W'(cfg.debounce)) begin
               deb_in = 1'b0;
               tag_in = NOT_PRESSED;
               if (ign_ff) begin
                  // release swallowed after a screen change
                  ign_in = 1'b0;
               end else begin
                  if (cfg.sound_enables[SND_EN_RELEASE]) begin
                     result.sound_kind = SND_RELEASE;
                  end
                  result.event_kind = EV_END;
                  result.event_tag  = tag_ff;
                  result.refresh    = 1'b1;
               end
            end
         end
      end
      result.held_tag = tag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= NOT_PRESSED;
         deb_ff <= 1'b0;
         ign_ff <= 1'b0;
         ctr_ff <= '0;
      end else if (step_en) begin
         tag_ff <= tag_in;
         deb_ff <= deb_in;
         ign_ff <= ign_in;
         ctr_ff <= ctr_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/touch_tag_debounce_repeat.sv =====
// touch tag debounce with auto-repeat
//
// req_ channel: one item per millisecond tick, carrying the panel's touch tag,
// the busy flag and the screen's answers to the previous start/held events.
// rsp_ channel: exactly one result item per input item, in order: event kind
// and tag, click sound, redraw request, the pressed tag after the tick and
// whether the tag was examined.
// csr_ port: plain write port, register i at index i, taken on csr_write_en.
// path: an item accepted into the input register is worked on by the tick logic
// and loaded into the result register once that register is free or draining,
// and rsp_valid rises as the result is loaded.
// throughput: one item per cycle while rsp_ready stays high; the tick logic
// updates its state as each item steps, so consecutive items need no spacing.
// stall: the two register stages form a pipeline; while rsp_ready is low the
// result holds and the input register still takes one more item.
// reset: pressed tag, debounce and ignore-release marks and the elapsed
// counter clear, registers return to their defaults, both stages empty.
`default_nettype none

module touch_tag_debounce_repeat
   import tdr_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // input items
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic [TAG_W-1:0]     req_touch_tag,
   input  wire logic                 req_panel_busy,
   input  wire logic                 req_start_accepted,
   input  wire logic                 req_held_accepted,
   input  wire logic                 req_screen_changed,
   // result items
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      logic [1:0]           rsp_event_kind,
   output      logic [TAG_W-1:0]     rsp_event_tag,
   output      logic [1:0]           rsp_sound_kind,
   output      logic                 rsp_refresh,
   output      logic [TAG_W-1:0]     rsp_held_tag,
   output      logic                 rsp_sampled,
   // configuration writes
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   // input register stage
   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   // result register stage
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type step_result;
   cfg_type    cfg_ff, cfg_in;
   logic       step_en;
   logic       req_take;

   // the tick runs when the input stage holds an item and the result
   // register is free or draining this cycle
   assign step_en   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_en;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !step_en);
   assign out_valid_in = step_en || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.touch_tag      <= req_touch_tag;
         in_item_ff.panel_busy     <= req_panel_busy;
         in_item_ff.start_accepted <= req_start_accepted;
         in_item_ff.held_accepted  <= req_held_accepted;
         in_item_ff.screen_changed <= req_screen_changed;
      end
      if (step_en) begin
         out_ff <= step_result;
      end
   end

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_UPDATE_INTERVAL: cfg_in.update_interval = csr_wdata;
            CSR_REPEAT_PERIOD:   cfg_in.repeat_period   = csr_wdata;
            CSR_DEBOUNCE:        cfg_in.debounce        = csr_wdata;
            CSR_SOUND_ENABLES:   cfg_in.sound_enables   = csr_wdata[SOUND_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.update_interval <= UPDATE_INTERVAL_RST;
         cfg_ff.repeat_period   <= REPEAT_PERIOD_RST;
         cfg_ff.debounce        <= DEBOUNCE_RST;
         cfg_ff.sound_enables   <= SOUND_ENABLES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // press/hold/release tracking and elapsed counter
   tdr_state #(
      .TIMER_BITS (TIMER_BITS)
   ) u_state (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .result  (step_result)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_kind = out_ff.event_kind;
   assign rsp_event_tag  = out_ff.event_tag;
   assign rsp_sound_kind = out_ff.sound_kind;
   assign rsp_refresh    = out_ff.refresh;
   assign rsp_held_tag   = out_ff.held_tag;
   assign rsp_sampled    = out_ff.sampled;

endmodule

`default_nettype wire

// ===== hw/rtl/tdr_checker.sv =====
`default_nettype none

module tdr_checker
   import tdr_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [1:0]       rsp_event_kind,
   input wire logic [TAG_W-1:0] rsp_event_tag,
   input wire logic [1:0]       rsp_sound_kind,
   input wire logic             rsp_refresh,
   input wire logic [TAG_W-1:0] rsp_held_tag,
   input wire logic             rsp_sampled
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind)
         && $stable(rsp_event_tag) && $stable(rsp_held_tag))
      else $error("result changed while stalled");

   // a tick that was not examined is silent
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sampled |-> rsp_event_kind == EV_NONE
         && rsp_sound_kind == SND_NONE && !rsp_refresh)
      else $error("unsampled tick produced activity");

   // no event carries no tag
   a_no_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_NONE |-> rsp_event_tag == NOT_PRESSED)
      else $error("tag without event");

   // start latches the tag and asks for a redraw
   a_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_START |->
         rsp_held_tag == rsp_event_tag && rsp_refresh
         && rsp_event_tag != NOT_PRESSED)
      else $error("bad touch start");

   // end releases the tag
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_END |->
         rsp_held_tag == NOT_PRESSED && rsp_event_tag != NOT_PRESSED)
      else $error("bad touch end");

endmodule

bind touch_tag_debounce_repeat tdr_checker u_tdr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_event_kind (rsp_event_kind),
   .rsp_event_tag  (rsp_event_tag),
   .rsp_sound_kind (rsp_sound_kind),
   .rsp_refresh    (rsp_refresh),
   .rsp_held_tag   (rsp_held_tag),
   .rsp_sampled    (rsp_sampled)
);

`default_nettype wire
